@@ sv/max_heap_priority_queue_core_defines.svh @@
// assertion macros for the max heap priority queue core
`ifndef MAX_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, checked on the rising edge of clk outside reset
`define MHPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mhpq: same-cycle check failed");

// next-cycle implication
`define MHPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mhpq: next-cycle check failed");

`endif

@@ sv/mhpq_pkg.sv @@
// types and codes shared by the heap priority queue modules
package mhpq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] removed_value;
    logic signed [31:0] top_value;
    logic        [6:0]  entry_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic ins_init;
    logic rem_init;
    logic take_last;
    logic rd_parent;
    logic rd_children;
    logic move_up;
    logic move_down;
    logic place;
    logic set_full;
    logic set_empty;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op;
    logic empty;
    logic full;
    logic one_left;
    logic at_root;
    logic has_left;
    logic parent_less;
    logic child_greater;
  } sts_t;

endpackage

@@ sv/mhpq_ctrl.sv @@
// sequencer for insert sift-up and remove sift-down
module mhpq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  input  mhpq_pkg::sts_t sts,
  output mhpq_pkg::cmd_t cmd
);
  import mhpq_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DECODE    = 3'd1;
  localparam logic [2:0] S_LOAD_LAST = 3'd2;
  localparam logic [2:0] S_UP_CHK    = 3'd3;
  localparam logic [2:0] S_UP_CMP    = 3'd4;
  localparam logic [2:0] S_DN_CHK    = 3'd5;
  localparam logic [2:0] S_DN_CMP    = 3'd6;
  localparam logic [2:0] S_FINISH    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       rsp_valid_next;
  logic       out_free;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.op == OP_INSERT) begin
          if (sts.full) begin
            cmd.set_full = 1'b1;
            state_next   = S_FINISH;
          end else begin
            cmd.ins_init = 1'b1;
            state_next   = S_UP_CHK;
          end
        end else begin
          if (sts.empty) begin
            cmd.set_empty = 1'b1;
            state_next    = S_FINISH;
          end else begin
            cmd.rem_init = 1'b1;
            // last entry removed leaves nothing to repair
            state_next   = sts.one_left ? S_FINISH : S_LOAD_LAST;
          end
        end
      end
      S_LOAD_LAST: begin
        cmd.take_last = 1'b1;
        state_next    = S_DN_CHK;
      end
      S_UP_CHK: begin
        if (sts.at_root) begin
          cmd.place  = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.parent_less) begin
          cmd.move_up = 1'b1;
          state_next  = S_UP_CHK;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_DN_CHK: begin
        if (!sts.has_left) begin
          cmd.place  = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.rd_children = 1'b1;
          state_next      = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts.child_greater) begin
          cmd.move_down = 1'b1;
          state_next    = S_DN_CHK;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    priority if (cmd.emit) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

@@ sv/mhpq_dp.sv @@
// heap memory, hole position, compare logic and result register
module mhpq_dp #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  mhpq_pkg::cmd_t cmd,
  output mhpq_pkg::sts_t sts,
  input  mhpq_pkg::req_t req,
  output mhpq_pkg::rsp_t rsp
);
  import mhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 2;

  logic signed [31:0] heap_mem [CAPACITY];

  logic               op_r;
  logic signed [31:0] val_r;
  logic signed [31:0] cur;
  logic [AW-1:0]      pos;
  logic [CW-1:0]      count;
  logic signed [31:0] top;
  logic signed [31:0] removed;
  logic [1:0]         status;
  logic signed [31:0] rd_a;
  logic signed [31:0] rd_b;

  logic [CW-1:0]      cnt_dec;
  logic [AW-1:0]      parent;
  logic [LW-1:0]      left;
  logic [LW-1:0]      right;
  logic [LW-1:0]      count_ext;
  logic               pick_right;
  logic [AW-1:0]      child_idx;
  logic signed [31:0] child_val;
  logic [AW-1:0]      ra;
  logic               we;
  logic signed [31:0] wdata;
  logic [31:0]        cnt_wide;

  assign cnt_dec    = count - CW'(1);
  assign parent     = (pos - AW'(1)) >> 1;
  assign left       = {1'b0, pos, 1'b1};
  assign right      = left + LW'(1);
  assign count_ext  = LW'(count);
  assign pick_right = (right < count_ext) && (rd_a < rd_b);
  assign child_idx  = pick_right ? right[AW-1:0] : left[AW-1:0];
  assign child_val  = pick_right ? rd_b : rd_a;
  assign cnt_wide   = 32'(count);

  always_comb begin
    priority if (cmd.rem_init) begin
      ra = cnt_dec[AW-1:0];
    end else if (cmd.rd_parent) begin
      ra = parent;
    end else begin
      ra = left[AW-1:0];
    end
  end

  // hole technique: the moving entry stays in cur until its slot is final
  assign we = cmd.place | cmd.move_up | cmd.move_down;
  always_comb begin
    priority if (cmd.place) begin
      wdata = cur;
    end else if (cmd.move_up) begin
      wdata = rd_a;
    end else begin
      wdata = child_val;
    end
  end

  assign sts.op            = op_r;
  assign sts.empty         = (count == '0);
  assign sts.full          = (count == CW'(CAPACITY));
  assign sts.one_left      = (count == CW'(1));
  assign sts.at_root       = (pos == '0);
  assign sts.has_left      = (left < count_ext);
  assign sts.parent_less   = (rd_a < cur);
  assign sts.child_greater = (cur < child_val);

  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[pos] <= wdata;
    end
    if (cmd.rem_init || cmd.rd_parent || cmd.rd_children) begin
      rd_a <= heap_mem[ra];
    end
    if (cmd.rd_children) begin
      rd_b <= heap_mem[right[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins_init) begin
      count <= count + CW'(1);
    end else if (cmd.rem_init) begin
      count <= cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= req.operation;
      val_r   <= req.value;
      removed <= '0;
      status  <= ST_OK;
    end
    if (cmd.set_full) begin
      status <= ST_FULL;
    end
    if (cmd.set_empty) begin
      status <= ST_EMPTY;
    end
    if (cmd.ins_init) begin
      pos <= count[AW-1:0];
      cur <= val_r;
    end
    if (cmd.rem_init) begin
      pos     <= '0;
      removed <= top;
    end
    if (cmd.take_last) begin
      cur <= rd_a;
    end
    if (cmd.move_up) begin
      pos <= parent;
    end
    if (cmd.move_down) begin
      pos <= child_idx;
    end
    // shadow copy of the root slot
    if (we && pos == '0) begin
      top <= wdata;
    end
    if (cmd.emit) begin
      rsp.status        <= status;
      rsp.removed_value <= removed;
      rsp.top_value     <= (count == '0) ? 32'sd0 : top;
      rsp.entry_count   <= cnt_wide[6:0];
    end
  end

endmodule

@@ sv/max_heap_priority_queue_core.sv @@
// top level of the binary max heap priority queue
//
//   channel | signals                      | payload
//   --------+------------------------------+--------------------------------------
//   req     | req_valid in, req_stall out  | operation, value
//   rsp     | rsp_valid out, rsp_stall in  | status, removed_value, top_value, count
//
// one transaction at a time; each heap level is a memory read followed by a
// compare and write
// reset empties the heap at once; the memory itself is never cleared
// a result waits in the output register while the next transaction is taken,
// and rsp_stall only holds the sequencer in its final state
module max_heap_priority_queue_core #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mhpq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mhpq_pkg::rsp_t rsp
);
  import mhpq_pkg::*;

  `include "max_heap_priority_queue_core_defines.svh"

  cmd_t cmd;
  sts_t sts;

  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .rsp (rsp)
  );

  `MHPQ_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
  `MHPQ_ASSERT_NOW(a_no_ins_when_full, cmd.ins_init, !sts.full)
  `MHPQ_ASSERT_NOW(a_no_rem_when_empty, cmd.rem_init, !sts.empty)
  `MHPQ_ASSERT_NOW(a_full_reports_cap, rsp_valid && rsp.status == ST_FULL, rsp.entry_count == 7'(CAPACITY))

endmodule
